// File: rtl/core/bsc_pkg.sv
// Shared types, constants and state encoding for the banker's safety checker.
package bsc_pkg;

    localparam int NUM_PROCS = 8;
    localparam int NUM_RES   = 4;
    localparam int RES_WIDTH = 8;
    localparam int PROC_W    = 3;
    localparam int ACT_W     = 4;
    localparam int SEQ_W     = 3;
    localparam int ADM_W     = 4;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = 4'd8;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic [2:0] REG_ACTIVE_PROCS = 3'd0;
    localparam logic [2:0] REG_AVAIL_0      = 3'd1;
    localparam logic [2:0] REG_AVAIL_1      = 3'd2;
    localparam logic [2:0] REG_AVAIL_2      = 3'd3;
    localparam logic [2:0] REG_AVAIL_3      = 3'd4;

    typedef logic [NUM_RES-1:0][RES_WIDTH-1:0] res_vec_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_CLOSE
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic rd_en;
        logic admit;
        logic adv;
        logic wrap;
        logic emit_close;
    } dp_cmd_t;

    typedef struct packed {
        logic can_admit;
        logic last_p;
        logic all_done_next;
        logic found;
        logic out_free;
        logic start_n_zero;
    } dp_sts_t;

endpackage

// File: rtl/core/bsc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bsc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/bsc_ctrl.sv
// Scan controller: sequences loads, row reads, admissions and the closing verdict.
module bsc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_op,
    output logic              s_ready,
    input  bsc_pkg::dp_sts_t  sts,
    output bsc_pkg::dp_cmd_t  cmd
);
    bsc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bsc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            bsc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == bsc_pkg::OP_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.start  = 1'b1;
                        state_next = sts.start_n_zero ? bsc_pkg::ST_CLOSE : bsc_pkg::ST_READ;
                    end
                end
            end
            bsc_pkg::ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = bsc_pkg::ST_EVAL;
            end
            bsc_pkg::ST_EVAL: begin
                if (sts.can_admit) begin
                    // hold on the row until the output stage has room
                    if (sts.out_free) begin
                        cmd.admit = 1'b1;
                        if (sts.all_done_next) begin
                            state_next = bsc_pkg::ST_CLOSE;
                        end else if (sts.last_p) begin
                            cmd.wrap   = 1'b1;
                            state_next = bsc_pkg::ST_READ;
                        end else begin
                            cmd.adv    = 1'b1;
                            state_next = bsc_pkg::ST_READ;
                        end
                    end
                end else if (sts.last_p) begin
                    if (sts.found) begin
                        cmd.wrap   = 1'b1;
                        state_next = bsc_pkg::ST_READ;
                    end else begin
                        state_next = bsc_pkg::ST_CLOSE;
                    end
                end else begin
                    cmd.adv    = 1'b1;
                    state_next = bsc_pkg::ST_READ;
                end
            end
            bsc_pkg::ST_CLOSE: begin
                if (sts.out_free) begin
                    cmd.emit_close = 1'b1;
                    state_next     = bsc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bsc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/bsc_dpath.sv
// Datapath: process table, work vector, finished flags, counters and result stage.
module bsc_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bsc_pkg::dp_cmd_t              cmd,
    output bsc_pkg::dp_sts_t              sts,
    input  logic [bsc_pkg::ACT_W-1:0]     active_procs,
    input  bsc_pkg::res_vec_t             avail,
    input  logic [bsc_pkg::PROC_W-1:0]    s_proc,
    input  bsc_pkg::res_vec_t             s_held,
    input  bsc_pkg::res_vec_t             s_claim,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_proc_valid,
    output logic [bsc_pkg::SEQ_W-1:0]     m_seq_proc,
    output logic                          m_safe,
    output logic [bsc_pkg::ADM_W-1:0]     m_admitted,
    output logic                          m_last
);
    localparam int NUM_PROCS = bsc_pkg::NUM_PROCS;
    localparam int PIDX_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int CNT_W  = $clog2(NUM_PROCS + 1);
    localparam int WORK_W = bsc_pkg::RES_WIDTH + $clog2(NUM_PROCS + 1);
    localparam int VEC_W  = bsc_pkg::NUM_RES * bsc_pkg::RES_WIDTH;
    localparam int ROW_W  = 2 * VEC_W;

    bsc_pkg::res_vec_t need_wr, held_rd, need_rd;
    logic [ROW_W-1:0]  row_rd;
    logic              row_we;

    logic [bsc_pkg::NUM_RES-1:0][WORK_W-1:0] work_reg, work_next;
    logic [NUM_PROCS-1:0] fin_reg, fin_next;
    logic [PIDX_W-1:0]    p_reg, p_next;
    logic [CNT_W-1:0]     count_reg, count_next, n_reg, n_next, count_inc;
    logic                 found_reg, found_next;
    logic                 fits;

    logic                        m_valid_reg, m_valid_next;
    logic                        m_proc_valid_reg, m_safe_reg, m_last_reg;
    logic [bsc_pkg::SEQ_W-1:0]   m_seq_proc_reg;
    logic [bsc_pkg::ADM_W-1:0]   m_admitted_reg;

    // need = claim - held, floored at zero
    always_comb begin
        for (int j = 0; j < bsc_pkg::NUM_RES; j++) begin
            need_wr[j] = (s_claim[j] >= s_held[j]) ? (s_claim[j] - s_held[j]) : '0;
        end
    end

    assign row_we = cmd.load && (32'(s_proc) < 32'(NUM_PROCS));

    bsc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_PROCS)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (PIDX_W'(s_proc)),
        .wdata ({need_wr, s_held}),
        .re    (cmd.rd_en),
        .raddr (p_reg),
        .rdata (row_rd)
    );

    assign held_rd = row_rd[VEC_W-1:0];
    assign need_rd = row_rd[ROW_W-1:VEC_W];

    always_comb begin
        fits = 1'b1;
        for (int j = 0; j < bsc_pkg::NUM_RES; j++) begin
            if (WORK_W'(need_rd[j]) > work_reg[j]) begin
                fits = 1'b0;
            end
        end
    end

    assign count_inc = count_reg + CNT_W'(1);

    assign sts.can_admit     = fits && !fin_reg[p_reg];
    assign sts.last_p        = (CNT_W'(p_reg) + CNT_W'(1)) == n_reg;
    assign sts.all_done_next = (count_inc == n_reg);
    assign sts.found         = found_reg;
    assign sts.out_free      = !m_valid_reg || m_ready;
    assign sts.start_n_zero  = (active_procs == '0);

    always_comb begin
        work_next  = work_reg;
        fin_next   = fin_reg;
        p_next     = p_reg;
        count_next = count_reg;
        n_next     = n_reg;
        found_next = found_reg;
        if (cmd.start) begin
            for (int j = 0; j < bsc_pkg::NUM_RES; j++) begin
                work_next[j] = WORK_W'(avail[j]);
            end
            fin_next   = '0;
            p_next     = '0;
            count_next = '0;
            found_next = 1'b0;
            n_next     = (32'(active_procs) > 32'(NUM_PROCS)) ? CNT_W'(NUM_PROCS)
                                                              : CNT_W'(active_procs);
        end else begin
            if (cmd.admit) begin
                for (int j = 0; j < bsc_pkg::NUM_RES; j++) begin
                    work_next[j] = work_reg[j] + WORK_W'(held_rd[j]);
                end
                fin_next[p_reg] = 1'b1;
                count_next      = count_inc;
                found_next      = 1'b1;
            end
            if (cmd.adv) begin
                p_next = p_reg + PIDX_W'(1);
            end
            if (cmd.wrap) begin
                p_next     = '0;
                found_next = 1'b0;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.admit || cmd.emit_close) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_reg     <= '0;
            p_reg       <= '0;
            count_reg   <= '0;
            n_reg       <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fin_reg     <= fin_next;
            p_reg       <= p_next;
            count_reg   <= count_next;
            n_reg       <= n_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        if (cmd.admit) begin
            m_proc_valid_reg <= 1'b1;
            m_seq_proc_reg   <= bsc_pkg::SEQ_W'(p_reg);
            m_safe_reg       <= 1'b0;
            m_admitted_reg   <= bsc_pkg::ADM_W'(count_inc);
            m_last_reg       <= 1'b0;
        end else if (cmd.emit_close) begin
            m_proc_valid_reg <= 1'b0;
            m_seq_proc_reg   <= '0;
            m_safe_reg       <= (count_reg >= n_reg);
            m_admitted_reg   <= bsc_pkg::ADM_W'(count_reg);
            m_last_reg       <= 1'b1;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_proc_valid = m_proc_valid_reg;
    assign m_seq_proc   = m_seq_proc_reg;
    assign m_safe       = m_safe_reg;
    assign m_admitted   = m_admitted_reg;
    assign m_last       = m_last_reg;

endmodule

// File: rtl/core/bankers_safety_check.sv
// Top level of the banker's safety checker: config registers, controller and datapath.
//
//   channel   direction  handshake         carries
//   s_*       in         s_valid/s_ready   one load row (op 0) or a check request (op 1)
//   m_*       out        m_valid/m_ready   one admitted process, or the closing verdict
//   apb       in/out     psel/penable      active_procs, avail_0..avail_3
//
// A load item is taken while the scan is idle. A check starts a scan that visits
// each active process once per pass, with one table read and one evaluation per
// visit, over every pass, and ends with the verdict.
// Reset is synchronous, active low; the process table holds no reset value.
// A full output register stalls the scan at the next admission or verdict only;
// new items are accepted whenever the scan is idle, even with a result waiting.
module bankers_safety_check (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bsc_pkg::PADDR_W-1:0]   paddr,
    input  logic [bsc_pkg::PDATA_W-1:0]   pwdata,
    output logic [bsc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // input items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [bsc_pkg::PROC_W-1:0]    s_proc,
    input  logic [bsc_pkg::RES_WIDTH-1:0] s_held_0,
    input  logic [bsc_pkg::RES_WIDTH-1:0] s_held_1,
    input  logic [bsc_pkg::RES_WIDTH-1:0] s_held_2,
    input  logic [bsc_pkg::RES_WIDTH-1:0] s_held_3,
    input  logic [bsc_pkg::RES_WIDTH-1:0] s_claim_0,
    input  logic [bsc_pkg::RES_WIDTH-1:0] s_claim_1,
    input  logic [bsc_pkg::RES_WIDTH-1:0] s_claim_2,
    input  logic [bsc_pkg::RES_WIDTH-1:0] s_claim_3,
    // result items
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_proc_valid,
    output logic [bsc_pkg::SEQ_W-1:0]     m_seq_proc,
    output logic                          m_safe,
    output logic [bsc_pkg::ADM_W-1:0]     m_admitted,
    output logic                          m_last
);
    logic [bsc_pkg::ACT_W-1:0] active_reg;
    bsc_pkg::res_vec_t         avail_reg;
    bsc_pkg::res_vec_t         held_vec, claim_vec;
    logic [2:0]                cfg_idx;
    logic                      cfg_wr;
    bsc_pkg::dp_cmd_t          cmd;
    bsc_pkg::dp_sts_t          sts;

    // Register index sits above the byte offset; pready is tied high, so the
    // access phase never waits.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= bsc_pkg::ACTIVE_RESET;
            avail_reg  <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                bsc_pkg::REG_ACTIVE_PROCS: active_reg   <= pwdata[bsc_pkg::ACT_W-1:0];
                bsc_pkg::REG_AVAIL_0:      avail_reg[0] <= pwdata[bsc_pkg::RES_WIDTH-1:0];
                bsc_pkg::REG_AVAIL_1:      avail_reg[1] <= pwdata[bsc_pkg::RES_WIDTH-1:0];
                bsc_pkg::REG_AVAIL_2:      avail_reg[2] <= pwdata[bsc_pkg::RES_WIDTH-1:0];
                bsc_pkg::REG_AVAIL_3:      avail_reg[3] <= pwdata[bsc_pkg::RES_WIDTH-1:0];
                default: begin
                    // drop writes past the register list
                end
            endcase
        end
    end

    // Read back; unused addresses return zero.
    always_comb begin
        prdata = '0;
        case (cfg_idx)
            bsc_pkg::REG_ACTIVE_PROCS: prdata = bsc_pkg::PDATA_W'(active_reg);
            bsc_pkg::REG_AVAIL_0:      prdata = bsc_pkg::PDATA_W'(avail_reg[0]);
            bsc_pkg::REG_AVAIL_1:      prdata = bsc_pkg::PDATA_W'(avail_reg[1]);
            bsc_pkg::REG_AVAIL_2:      prdata = bsc_pkg::PDATA_W'(avail_reg[2]);
            bsc_pkg::REG_AVAIL_3:      prdata = bsc_pkg::PDATA_W'(avail_reg[3]);
            default:                   prdata = '0;
        endcase
    end

    // Gather the per-resource fields into vectors, resource 0 lowest.
    assign held_vec  = {s_held_3, s_held_2, s_held_1, s_held_0};
    assign claim_vec = {s_claim_3, s_claim_2, s_claim_1, s_claim_0};

    bsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bsc_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .active_procs (active_reg),
        .avail        (avail_reg),
        .s_proc       (s_proc),
        .s_held       (held_vec),
        .s_claim      (claim_vec),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_proc_valid (m_proc_valid),
        .m_seq_proc   (m_seq_proc),
        .m_safe       (m_safe),
        .m_admitted   (m_admitted),
        .m_last       (m_last)
    );

endmodule

// File: rtl/core/bsc_checker.sv
// Port-level assertions for the banker's safety checker, bound to the top level.
module bsc_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      pready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_proc_valid,
    input logic [bsc_pkg::SEQ_W-1:0] m_seq_proc,
    input logic                      m_safe,
    input logic [bsc_pkg::ADM_W-1:0] m_admitted,
    input logic                      m_last
);
    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_proc_valid) && $stable(m_seq_proc)
            && $stable(m_safe) && $stable(m_admitted) && $stable(m_last))
        else $error("result changed while stalled");

    // The verdict names no process.
    a_close_fmt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> !m_proc_valid && (m_seq_proc == '0))
        else $error("closing item malformed");

    // An admission is never the closing item and always counts itself.
    a_admit_fmt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_proc_valid |-> !m_last && !m_safe && (m_admitted != '0))
        else $error("admission item malformed");

    // Exactly one of the two kinds of item.
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_proc_valid != m_last))
        else $error("item is neither admission nor verdict");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready dropped");

endmodule

bind bankers_safety_check bsc_checker u_bsc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .pready       (pready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_proc_valid (m_proc_valid),
    .m_seq_proc   (m_seq_proc),
    .m_safe       (m_safe),
    .m_admitted   (m_admitted),
    .m_last       (m_last)
);

// File: sim/bsc_checker.sv
// Scoreboard for the banker's safety checker: predicts every scan result and compares it.
`timescale 1ns / 100ps

module bsc_scoreboard #(
    parameter int NUM_PROCS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [bsc_pkg::PADDR_W-1:0]   paddr,
    input  logic [bsc_pkg::PDATA_W-1:0]   pwdata,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_op,
    input  logic [bsc_pkg::PROC_W-1:0]    s_proc,
    input  bsc_pkg::res_vec_t             s_held,
    input  bsc_pkg::res_vec_t             s_claim,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_proc_valid,
    input  logic [bsc_pkg::SEQ_W-1:0]     m_seq_proc,
    input  logic                          m_safe,
    input  logic [bsc_pkg::ADM_W-1:0]     m_admitted,
    input  logic                          m_last,
    output int                            errors,
    output int                            pending
);
    import bsc_pkg::*;

    typedef struct packed {
        logic             proc_valid;
        logic [SEQ_W-1:0] seq_proc;
        logic             safe;
        logic [ADM_W-1:0] admitted;
        logic             last;
    } scan_result_t;

    logic [ACT_W-1:0] active_cfg;
    res_vec_t         avail_cfg;
    res_vec_t         held_rows [NUM_PROCS];
    res_vec_t         need_rows [NUM_PROCS];
    scan_result_t     scan_results_q [$];

    // Walk the active rows in passes until everyone is in or a pass admits nobody.
    function automatic void run_safety_scan();
        int unsigned      work [NUM_RES];
        logic [NUM_PROCS-1:0] done;
        int               n;
        int               count;
        bit               progress;
        bit               fits;
        scan_result_t     r;
        n = (int'(active_cfg) > NUM_PROCS) ? NUM_PROCS : int'(active_cfg);
        for (int j = 0; j < NUM_RES; j++)
            work[j] = avail_cfg[j];
        done     = '0;
        count    = 0;
        progress = 1'b1;
        while (count < n && progress) begin
            progress = 1'b0;
            for (int p = 0; p < n; p++) begin
                if (!done[p]) begin
                    fits = 1'b1;
                    for (int j = 0; j < NUM_RES; j++)
                        if (need_rows[p][j] > work[j])
                            fits = 1'b0;
                    if (fits) begin
                        for (int j = 0; j < NUM_RES; j++)
                            work[j] += held_rows[p][j];
                        done[p]      = 1'b1;
                        count++;
                        progress     = 1'b1;
                        r.proc_valid = 1'b1;
                        r.seq_proc   = SEQ_W'(p);
                        r.safe       = 1'b0;
                        r.admitted   = ADM_W'(count);
                        r.last       = 1'b0;
                        scan_results_q.push_back(r);
                    end
                end
            end
        end
        r.proc_valid = 1'b0;
        r.seq_proc   = '0;
        r.safe       = (count >= n);
        r.admitted   = ADM_W'(count);
        r.last       = 1'b1;
        scan_results_q.push_back(r);
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        scan_result_t want;
        if (!aresetn) begin
            active_cfg = ACTIVE_RESET;
            avail_cfg  = '0;
            errors     = 0;
            scan_results_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_ACTIVE_PROCS: active_cfg   = pwdata[ACT_W-1:0];
                    REG_AVAIL_0:      avail_cfg[0] = pwdata[RES_WIDTH-1:0];
                    REG_AVAIL_1:      avail_cfg[1] = pwdata[RES_WIDTH-1:0];
                    REG_AVAIL_2:      avail_cfg[2] = pwdata[RES_WIDTH-1:0];
                    REG_AVAIL_3:      avail_cfg[3] = pwdata[RES_WIDTH-1:0];
                    default: ;
                endcase
            end
            // Pop before push: a result never belongs to a check taken in the same cycle.
            if (m_valid && m_ready) begin
                if (scan_results_q.size() == 0) begin
                    $display({"%0t: result mismatch, expected none, actual proc_valid %0d",
                              " seq_proc %0d safe %0d admitted %0d last %0d"},
                             $time, m_proc_valid, m_seq_proc, m_safe, m_admitted, m_last);
                    errors++;
                end else begin
                    want = scan_results_q.pop_front();
                    compare_field("proc_valid", want.proc_valid, m_proc_valid);
                    compare_field("seq_proc", want.seq_proc, m_seq_proc);
                    compare_field("safe", want.safe, m_safe);
                    compare_field("admitted", want.admitted, m_admitted);
                    compare_field("last", want.last, m_last);
                end
            end
            if (s_valid && s_ready) begin
                if (s_op == OP_CHECK) begin
                    run_safety_scan();
                end else if (s_proc < NUM_PROCS) begin
                    for (int j = 0; j < NUM_RES; j++) begin
                        held_rows[s_proc][j] = s_held[j];
                        need_rows[s_proc][j] = (s_claim[j] >= s_held[j]) ?
                                               s_claim[j] - s_held[j] : '0;
                    end
                end
            end
        end
        pending = scan_results_q.size();
    end

endmodule

// File: sim/tb.sv
// Top of the banker's safety checker testbench: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb;
    import bsc_pkg::*;

    // Sized from the slowest check for n = 8, padded for the output stage.
    localparam int QUIET_CYCLES   = 2 * 8 * 8 + 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 36;
    localparam int CHECK_PCT      = 25;
    // Register slot past the end of the map; writes there must change nothing.
    localparam logic [2:0] REG_UNUSED = 3'd5;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_op;
    logic [PROC_W-1:0]    s_proc;
    logic [RES_WIDTH-1:0] s_held_0, s_held_1, s_held_2, s_held_3;
    logic [RES_WIDTH-1:0] s_claim_0, s_claim_1, s_claim_2, s_claim_3;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_proc_valid;
    logic [SEQ_W-1:0]     m_seq_proc;
    logic                 m_safe;
    logic [ADM_W-1:0]     m_admitted;
    logic                 m_last;

    int errors;
    int pending;
    int tx_gap_pct  = 0;
    int rx_idle_pct = 0;
    int quiet_run   = 0;
    bit hold_long   = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    bankers_safety_check dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_proc       (s_proc),
        .s_held_0     (s_held_0),
        .s_held_1     (s_held_1),
        .s_held_2     (s_held_2),
        .s_held_3     (s_held_3),
        .s_claim_0    (s_claim_0),
        .s_claim_1    (s_claim_1),
        .s_claim_2    (s_claim_2),
        .s_claim_3    (s_claim_3),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_proc_valid (m_proc_valid),
        .m_seq_proc   (m_seq_proc),
        .m_safe       (m_safe),
        .m_admitted   (m_admitted),
        .m_last       (m_last)
    );

    bsc_scoreboard #(.NUM_PROCS(8)) scan_monitor (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_proc       (s_proc),
        .s_held       ({s_held_3, s_held_2, s_held_1, s_held_0}),
        .s_claim      ({s_claim_3, s_claim_2, s_claim_1, s_claim_0}),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_proc_valid (m_proc_valid),
        .m_seq_proc   (m_seq_proc),
        .m_safe       (m_safe),
        .m_admitted   (m_admitted),
        .m_last       (m_last),
        .errors       (errors),
        .pending      (pending)
    );

    // Watchdog: trip when neither channel nor the register port moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_run <= 0;
        end else if (quiet_run >= WATCHDOG_LIMIT) begin
            $display("bankers_safety_check test failed");
            $finish;
        end else begin
            quiet_run <= quiet_run + 1;
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request so the
    // scan backs up and the block has to stop taking items.
    initial begin : receiver
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_long) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_long = 1'b0;
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 99) < rx_idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Two-phase register write; drops psel after the access and waits for the next
    // edge, so a following write never re-drives psel in the same step.
    task automatic apb_write(input logic [2:0] index, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        // Fill the unused upper bits with noise; the register must drop them.
        pwdata  <= ($urandom() & 32'hFFFF_FF00) | value;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        while (!pready) @(negedge aclk);
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Drain every outstanding result, let a trailing load settle, then program all
    // five registers.
    task automatic configure(input logic [3:0] active, input res_vec_t avail);
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
        apb_write(REG_ACTIVE_PROCS, {4'($urandom()), active});
        apb_write(REG_AVAIL_0, avail[0]);
        apb_write(REG_AVAIL_1, avail[1]);
        apb_write(REG_AVAIL_2, avail[2]);
        apb_write(REG_AVAIL_3, avail[3]);
    endtask

    // Offer one item and return at the edge that takes it. Sample ready on the
    // falling edge, where everything has settled.
    task automatic send_item(input logic op, input logic [2:0] proc,
                             input res_vec_t held, input res_vec_t claim);
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_proc    <= proc;
        s_held_0  <= held[0];
        s_held_1  <= held[1];
        s_held_2  <= held[2];
        s_held_3  <= held[3];
        s_claim_0 <= claim[0];
        s_claim_1 <= claim[1];
        s_claim_2 <= claim[2];
        s_claim_3 <= claim[3];
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    initial begin : stimulus
        res_vec_t   held;
        res_vec_t   claim;
        res_vec_t   avail;
        logic [3:0] active;
        int         pick;
        int         kind;

        aresetn   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        s_valid   = 1'b0;
        s_op      = OP_LOAD;
        s_proc    = '0;
        s_held_0  = '0;
        s_held_1  = '0;
        s_held_2  = '0;
        s_held_3  = '0;
        s_claim_0 = '0;
        s_claim_1 = '0;
        s_claim_2 = '0;
        s_claim_3 = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Full supply: load every row before the first check so no scan ever
        // touches an unwritten row. Row 0 claims below its holdings (need zero),
        // row 1 needs the whole supply, row 2 toggles alternate bits.
        configure(4'd8, {4{8'd255}});
        send_item(OP_LOAD, 3'd0, {4{8'd255}}, '0);
        send_item(OP_LOAD, 3'd1, '0, {4{8'd255}});
        send_item(OP_LOAD, 3'd2, {4{8'h55}}, {4{8'hAA}});
        for (int p = 3; p < 8; p++)
            send_item(OP_LOAD, 3'(p), 32'($urandom()), 32'($urandom()));
        send_item(OP_CHECK, '0, '0, '0);

        // Active count above the table size saturates; nothing free at start.
        // Also hit an address past the register map.
        configure(4'd15, '0);
        apb_write(REG_UNUSED, 8'hFF);
        send_item(OP_CHECK, '0, '0, '0);

        // Nobody active: safe with nobody admitted.
        configure(4'd0, {4{8'd9}});
        send_item(OP_CHECK, '0, '0, '0);

        // One process: claim equal to held admits it, a full claim deadlocks.
        configure(4'd1, '0);
        send_item(OP_LOAD, 3'd0, {4{8'd7}}, {4{8'd7}});
        send_item(OP_CHECK, '0, '0, '0);
        send_item(OP_LOAD, 3'd0, '0, {4{8'd255}});
        send_item(OP_CHECK, '0, '0, '0);

        // Reverse chain: each pass admits exactly one process, from 7 down to 0,
        // which forces the longest scan.
        configure(4'd8, '0);
        for (int p = 0; p < 8; p++)
            send_item(OP_LOAD, 3'(p), {4{8'd1}}, {4{8'(8 - p)}});
        send_item(OP_CHECK, '0, '0, '0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            pick = $urandom_range(0, 9);
            active = (pick == 0) ? 4'd0 :
                     (pick == 1) ? 4'($urandom_range(9, 15)) :
                     (pick == 2) ? 4'd8 : 4'($urandom_range(1, 8));
            for (int j = 0; j < NUM_RES; j++) begin
                pick = $urandom_range(0, 9);
                avail[j] = (pick == 0) ? 8'd0 :
                           (pick == 1) ? 8'd255 : 8'($urandom_range(0, 40));
            end
            configure(active, avail);

            // Drop all idling in the closing phases.
            if (ph >= NUM_PHASES - 2) begin
                tx_gap_pct  = 0;
                rx_idle_pct = 0;
            end else begin
                tx_gap_pct  = 20 * $urandom_range(0, 2);
                rx_idle_pct = 8 * $urandom_range(0, 2);
            end
            // Hold the result side off while items keep coming.
            if (ph == 2)
                hold_long = 1'b1;

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 99) < CHECK_PCT) begin
                    // Fields other than op carry noise on a check.
                    send_item(OP_CHECK, 3'($urandom()), 32'($urandom()), 32'($urandom()));
                end else begin
                    kind = $urandom_range(0, 9);
                    for (int j = 0; j < NUM_RES; j++) begin
                        if (kind < 6) begin
                            // Small holdings and modest needs: scans that get somewhere.
                            held[j]  = 8'($urandom_range(0, 15));
                            claim[j] = held[j] + 8'($urandom_range(0, 24));
                        end else if (kind < 8) begin
                            // Claim below held: counts as no need.
                            held[j]  = 8'($urandom_range(1, 255));
                            claim[j] = 8'($urandom_range(0, held[j] - 1));
                        end else begin
                            held[j]  = 8'($urandom());
                            claim[j] = 8'($urandom());
                        end
                    end
                    send_item(OP_LOAD, 3'($urandom_range(0, 7)), held, claim);
                end
            end
        end

        // Drain, then give a late or stray result time to show up.
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("bankers_safety_check test passed");
        else
            $display("bankers_safety_check test failed");
        $finish;
    end

endmodule
